// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- rtl/core/fqkr_pkg.sv -----
// types and constants of the keyed-removal queue
package fqkr_pkg;

   localparam int ID_W  = 32;
   localparam int TAG_W = 32;
   localparam int OP_W  = 2;
   localparam int OCC_W = 5;

   localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
   localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE  = 2'd2;

   // control broadcast from the top level to every cell
   typedef struct packed {
      logic                     fire;
      logic                     enq;
      logic                     deq;
      logic                     rem;
      logic signed [ID_W-1:0]   key_id;
      logic signed [TAG_W-1:0]  key_tag;
   } cell_ctrl_type;

endpackage

// ----- rtl/core/fqkr_ifs.sv -----
// request and response channel interfaces of the keyed-removal queue
interface fqkr_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [fqkr_pkg::OP_W-1:0]             operation;
   logic signed [fqkr_pkg::ID_W-1:0]      item_id;
   logic signed [fqkr_pkg::TAG_W-1:0]     item_tag;

   modport source (output valid, output operation, output item_id, output item_tag,
                   input ready);
   modport sink   (input valid, input operation, input item_id, input item_tag,
                   output ready);
endinterface

interface fqkr_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  ok;
   logic signed [fqkr_pkg::ID_W-1:0]      out_id;
   logic signed [fqkr_pkg::TAG_W-1:0]     out_tag;
   logic [fqkr_pkg::OCC_W-1:0]            occupancy;
   logic                                  is_empty;

   modport source (output valid, output ok, output out_id, output out_tag,
                   output occupancy, output is_empty, input ready);
   modport sink   (input valid, input ok, input out_id, input out_tag,
                   input occupancy, input is_empty, output ready);
endinterface

// ----- rtl/core/fqkr_cell.sv -----
// one queue slot: holds an entry, matches the key and shifts toward the head
module fqkr_cell #(
   parameter int IDX = 0,
   parameter int CW  = 5
) (
   input  logic                                clock,
   input  fqkr_pkg::cell_ctrl_type             ctrl,
   input  logic [CW-1:0]                       count,
   input  logic signed [fqkr_pkg::ID_W-1:0]    nxt_id,
   input  logic signed [fqkr_pkg::TAG_W-1:0]   nxt_tag,
   input  logic                                hit_prev,
   input  logic signed [fqkr_pkg::ID_W-1:0]    fnd_id_prev,
   input  logic signed [fqkr_pkg::TAG_W-1:0]   fnd_tag_prev,
   output logic signed [fqkr_pkg::ID_W-1:0]    slot_id,
   output logic signed [fqkr_pkg::TAG_W-1:0]   slot_tag,
   output logic                                hit_next,
   output logic signed [fqkr_pkg::ID_W-1:0]    fnd_id_next,
   output logic signed [fqkr_pkg::TAG_W-1:0]   fnd_tag_next
);

   logic signed [fqkr_pkg::ID_W-1:0]  id_ff, id_in;
   logic signed [fqkr_pkg::TAG_W-1:0] tag_ff, tag_in;
   logic                              occupied;
   logic                              match;
   logic                              shift;
   logic                              load;

   assign occupied = count > CW'(IDX);
   assign match    = occupied && (id_ff == ctrl.key_id) && (tag_ff == ctrl.key_tag);
   assign hit_next = hit_prev | match;

   assign fnd_id_next  = hit_prev ? fnd_id_prev  : (match ? id_ff  : '0);
   assign fnd_tag_next = hit_prev ? fnd_tag_prev : (match ? tag_ff : '0);

   assign shift = ctrl.deq | (ctrl.rem & hit_next);
   assign load  = ctrl.enq & (count == CW'(IDX));

   always_comb begin
      id_in  = id_ff;
      tag_in = tag_ff;
      if (ctrl.fire && shift) begin
         id_in  = nxt_id;
         tag_in = nxt_tag;
      end else if (ctrl.fire && load) begin
         id_in  = ctrl.key_id;
         tag_in = ctrl.key_tag;
      end
   end

   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      tag_ff <= tag_in;
   end

   assign slot_id  = id_ff;
   assign slot_tag = tag_ff;

endmodule

// ----- rtl/core/fifo_queue_with_keyed_removal.sv -----
// top level of the fifo queue of (id, tag) words with removal by key
// A chain of CAPACITY cells holds the entries in order with the head in the
// first cell, and every operation completes in the cycle it is accepted.
// Enqueue loads the cell at the fill count, dequeue moves every cell one place
// toward the head, and remove compares the key in all cells at once while a
// one-bit priority chain running through the cells marks the first match and
// every cell behind it, which all move one place. The response is held in an
// output register, so a new request is taken whenever that register is empty
// or being drained; one request word is taken per clock while the receiver
// keeps ready high. The clock period is set by the removal priority chain,
// whose length grows with CAPACITY. The queue is empty after reset; occupancy
// reports the entry count modulo 32.
module fifo_queue_with_keyed_removal #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   fqkr_req_if.sink    req_ch,
   fqkr_rsp_if.source  rsp_ch
);

   localparam int CW = $clog2(CAPACITY + 1);

   fqkr_pkg::cell_ctrl_type            ctrl;
   logic [CW-1:0]                      count_ff, count_in;
   logic                               full;
   logic                               empty;
   logic                               fire;

   logic signed [fqkr_pkg::ID_W-1:0]   cid  [CAPACITY];
   logic signed [fqkr_pkg::TAG_W-1:0]  ctag [CAPACITY];
   logic                               hit  [CAPACITY+1];
   logic signed [fqkr_pkg::ID_W-1:0]   fid  [CAPACITY+1];
   logic signed [fqkr_pkg::TAG_W-1:0]  ftag [CAPACITY+1];

   logic                               ok;
   logic signed [fqkr_pkg::ID_W-1:0]   res_id;
   logic signed [fqkr_pkg::TAG_W-1:0]  res_tag;
   logic [31:0]                        cnt_wide;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               ok_ff;
   logic signed [fqkr_pkg::ID_W-1:0]   out_id_ff;
   logic signed [fqkr_pkg::TAG_W-1:0]  out_tag_ff;
   logic [fqkr_pkg::OCC_W-1:0]         occ_ff;
   logic                               empty_ff;

   assign req_ch.ready = ~rsp_valid_ff | rsp_ch.ready;
   assign fire         = req_ch.valid & req_ch.ready;
   assign full         = count_ff == CW'(CAPACITY);
   assign empty        = count_ff == '0;

   assign ctrl.fire    = fire;
   assign ctrl.enq     = req_ch.operation == fqkr_pkg::OP_ENQUEUE;
   assign ctrl.deq     = req_ch.operation == fqkr_pkg::OP_DEQUEUE;
   assign ctrl.rem     = req_ch.operation == fqkr_pkg::OP_REMOVE;
   assign ctrl.key_id  = req_ch.item_id;
   assign ctrl.key_tag = req_ch.item_tag;

   assign hit[0]  = 1'b0;
   assign fid[0]  = '0;
   assign ftag[0] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [fqkr_pkg::ID_W-1:0]  nid;
      logic signed [fqkr_pkg::TAG_W-1:0] ntag;
      if (i == CAPACITY - 1) begin : g_last
         assign nid  = '0;
         assign ntag = '0;
      end else begin : g_mid
         assign nid  = cid[i+1];
         assign ntag = ctag[i+1];
      end
      fqkr_cell #(
         .IDX (i),
         .CW  (CW)
      ) u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .count        (count_ff),
         .nxt_id       (nid),
         .nxt_tag      (ntag),
         .hit_prev     (hit[i]),
         .fnd_id_prev  (fid[i]),
         .fnd_tag_prev (ftag[i]),
         .slot_id      (cid[i]),
         .slot_tag     (ctag[i]),
         .hit_next     (hit[i+1]),
         .fnd_id_next  (fid[i+1]),
         .fnd_tag_next (ftag[i+1])
      );
   end

   always_comb begin
      ok       = 1'b0;
      res_id   = '0;
      res_tag  = '0;
      count_in = count_ff;
      case (req_ch.operation)
         fqkr_pkg::OP_ENQUEUE: begin
            ok = ~full;
            if (!full) count_in = count_ff + CW'(1);
         end
         fqkr_pkg::OP_DEQUEUE: begin
            ok = ~empty;
            if (!empty) begin
               res_id   = cid[0];
               res_tag  = ctag[0];
               count_in = count_ff - CW'(1);
            end
         end
         fqkr_pkg::OP_REMOVE: begin
            ok = hit[CAPACITY];
            if (hit[CAPACITY]) begin
               res_id   = fid[CAPACITY];
               res_tag  = ftag[CAPACITY];
               count_in = count_ff - CW'(1);
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   assign cnt_wide     = 32'(count_in);
   assign rsp_valid_in = fire | (rsp_valid_ff & ~rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         ok_ff      <= ok;
         out_id_ff  <= res_id;
         out_tag_ff <= res_tag;
         occ_ff     <= cnt_wide[fqkr_pkg::OCC_W-1:0];
         empty_ff   <= count_in == '0;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.ok        = ok_ff;
   assign rsp_ch.out_id    = out_id_ff;
   assign rsp_ch.out_tag   = out_tag_ff;
   assign rsp_ch.occupancy = occ_ff;
   assign rsp_ch.is_empty  = empty_ff;

endmodule

// ----- rtl/core/fqkr_checker.sv -----
// port-level checks of the keyed-removal queue and their bind
`include "assert_macros.svh"

module fqkr_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_ok,
   input logic signed [fqkr_pkg::ID_W-1:0]    rsp_out_id,
   input logic signed [fqkr_pkg::TAG_W-1:0]   rsp_out_tag,
   input logic [fqkr_pkg::OCC_W-1:0]          rsp_occupancy,
   input logic                                rsp_is_empty
);

   // a stalled response word stays presented
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // an empty queue reports zero entries
   `ASSERT_IMPLY(a_empty_occ, clock, reset, rsp_valid && rsp_is_empty, rsp_occupancy == '0)

   // a refused operation returns a zero pair
   `ASSERT_IMPLY(a_fail_zero, clock, reset, rsp_valid && !rsp_ok,
                 rsp_out_id == '0 && rsp_out_tag == '0)

   // an accepted request always yields a response word next cycle
   `ASSERT_NEXT(a_req_rsp, clock, reset, req_valid && req_ready, rsp_valid)

endmodule

bind fifo_queue_with_keyed_removal fqkr_checker u_fqkr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_ok        (rsp_ch.ok),
   .rsp_out_id    (rsp_ch.out_id),
   .rsp_out_tag   (rsp_ch.out_tag),
   .rsp_occupancy (rsp_ch.occupancy),
   .rsp_is_empty  (rsp_ch.is_empty)
);

// ----- tb/sv/fifo_queue_with_keyed_removal_tb.sv -----
// testbench for the keyed-removal fifo queue: table-driven and random words, predicted
`timescale 1ns / 100ps

module fifo_queue_with_keyed_removal_tb;

   localparam int CAPACITY         = 16;
   localparam int RANDOM_PER_PHASE = 417;
   localparam int HOLD_CYCLES      = 48;
   localparam int DRAIN_CYCLES     = 10;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int N_ROWS           = 18;

   localparam logic [fqkr_pkg::OP_W-1:0]        OP_UNUSED = 2'd3;
   localparam logic signed [fqkr_pkg::ID_W-1:0] VAL_MAX   = 32'sh7fffffff;
   localparam logic signed [fqkr_pkg::ID_W-1:0] VAL_MIN   = 32'sh80000000;
   localparam logic signed [fqkr_pkg::ID_W-1:0] NO_TAG    = -32'sd1;

   typedef struct packed {
      logic                              ok;
      logic signed [fqkr_pkg::ID_W-1:0]  out_id;
      logic signed [fqkr_pkg::TAG_W-1:0] out_tag;
      logic [fqkr_pkg::OCC_W-1:0]        occupancy;
      logic                              is_empty;
   } queue_reply_type;

   typedef struct packed {
      logic signed [fqkr_pkg::ID_W-1:0]  id;
      logic signed [fqkr_pkg::TAG_W-1:0] tag;
   } queue_entry_type;

   typedef struct {
      logic [fqkr_pkg::OP_W-1:0]         op;
      logic signed [fqkr_pkg::ID_W-1:0]  id;
      logic signed [fqkr_pkg::TAG_W-1:0] tag;
      int                                reps;
      bit                                typed;
      queue_reply_type                   reply;
   } script_row_type;

   logic clock;
   logic reset;

   fqkr_req_if req_bus ();
   fqkr_rsp_if rsp_bus ();

   fifo_queue_with_keyed_removal #(.CAPACITY(CAPACITY)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   queue_entry_type model_entries[$];
   queue_reply_type awaited_replies[$];
   int              mismatch_count = 0;
   int              reply_count    = 0;
   int              cycle_count    = 0;
   int              send_idle_pct  = 0;
   int              recv_idle_pct  = 0;
   int              phase_idx      = 0;
   bit              hold_done      = 1'b0;

   // directed words; rows with typed set carry their reply, the rest are predicted
   script_row_type script [N_ROWS] = '{
      '{fqkr_pkg::OP_DEQUEUE, 32'sd0,  32'sd0,  1, 1'b1,
        '{1'b0, 32'sd0, 32'sd0, 5'd0, 1'b1}},
      '{fqkr_pkg::OP_REMOVE,  NO_TAG,  NO_TAG,  1, 1'b1,
        '{1'b0, 32'sd0, 32'sd0, 5'd0, 1'b1}},
      '{OP_UNUSED,            VAL_MAX, VAL_MAX, 1, 1'b1,
        '{1'b0, 32'sd0, 32'sd0, 5'd0, 1'b1}},
      '{fqkr_pkg::OP_ENQUEUE, VAL_MAX, VAL_MIN, 1, 1'b1,
        '{1'b1, 32'sd0, 32'sd0, 5'd1, 1'b0}},
      '{fqkr_pkg::OP_ENQUEUE, VAL_MIN, VAL_MAX, 1, 1'b1,
        '{1'b1, 32'sd0, 32'sd0, 5'd2, 1'b0}},
      '{fqkr_pkg::OP_ENQUEUE, NO_TAG,  NO_TAG,  1, 1'b1,
        '{1'b1, 32'sd0, 32'sd0, 5'd3, 1'b0}},
      '{fqkr_pkg::OP_ENQUEUE, 32'sd0,  32'sd0,  1, 1'b1,
        '{1'b1, 32'sd0, 32'sd0, 5'd4, 1'b0}},
      '{fqkr_pkg::OP_REMOVE,  NO_TAG,  NO_TAG,  1, 1'b1,
        '{1'b1, NO_TAG, NO_TAG, 5'd3, 1'b0}},
      '{fqkr_pkg::OP_REMOVE,  VAL_MAX, 32'sd0,  1, 1'b1,
        '{1'b0, 32'sd0, 32'sd0, 5'd3, 1'b0}},
      '{fqkr_pkg::OP_DEQUEUE, 32'sd0,  32'sd0,  1, 1'b1,
        '{1'b1, VAL_MAX, VAL_MIN, 5'd2, 1'b0}},
      '{OP_UNUSED,            32'sd0,  32'sd0,  1, 1'b1,
        '{1'b0, 32'sd0, 32'sd0, 5'd2, 1'b0}},
      '{fqkr_pkg::OP_ENQUEUE, 32'sd1000, 32'sd100, 14, 1'b0, '0},
      '{fqkr_pkg::OP_ENQUEUE, 32'sd5,  32'sd5,  1, 1'b1,
        '{1'b0, 32'sd0, 32'sd0, 5'd16, 1'b0}},
      '{fqkr_pkg::OP_REMOVE,  32'sd1007, 32'sd93, 1, 1'b0, '0},
      '{fqkr_pkg::OP_REMOVE,  32'sd0,  32'sd0,  1, 1'b0, '0},
      '{fqkr_pkg::OP_ENQUEUE, 32'sd1001, 32'sd99, 1, 1'b0, '0},
      '{fqkr_pkg::OP_REMOVE,  32'sd1001, 32'sd99, 1, 1'b0, '0},
      '{fqkr_pkg::OP_DEQUEUE, 32'sd0,  32'sd0,  1, 1'b0, '0}
   };

   always #5 clock = ~clock;

   function automatic queue_reply_type apply_queue_op(
         input logic [fqkr_pkg::OP_W-1:0]         op,
         input logic signed [fqkr_pkg::ID_W-1:0]  id,
         input logic signed [fqkr_pkg::TAG_W-1:0] tag);
      queue_reply_type reply;
      queue_entry_type head;
      bit              found;
      reply = '0;
      found = 1'b0;
      case (op)
         fqkr_pkg::OP_ENQUEUE: begin
            if (model_entries.size() < CAPACITY) begin
               model_entries.push_back(queue_entry_type'{id, tag});
               reply.ok = 1'b1;
            end
         end
         fqkr_pkg::OP_DEQUEUE: begin
            if (model_entries.size() > 0) begin
               head          = model_entries.pop_front();
               reply.ok      = 1'b1;
               reply.out_id  = head.id;
               reply.out_tag = head.tag;
            end
         end
         fqkr_pkg::OP_REMOVE: begin
            for (int k = 0; k < model_entries.size() && !found; k++) begin
               if (model_entries[k].id == id && model_entries[k].tag == tag) begin
                  found         = 1'b1;
                  reply.ok      = 1'b1;
                  reply.out_id  = model_entries[k].id;
                  reply.out_tag = model_entries[k].tag;
                  model_entries.delete(k);
               end
            end
         end
         default: ;
      endcase
      reply.occupancy = fqkr_pkg::OCC_W'(model_entries.size());
      reply.is_empty  = (model_entries.size() == 0);
      return reply;
   endfunction

   // extremes, small values for repeated keys, and full-range noise
   function automatic logic signed [fqkr_pkg::ID_W-1:0] pick_value();
      case ($urandom_range(9))
         0:       return VAL_MAX;
         1:       return VAL_MIN;
         2:       return NO_TAG;
         3:       return 32'sd0;
         4, 5:    return fqkr_pkg::ID_W'($urandom_range(3));
         default: return $urandom;
      endcase
   endfunction

   task automatic send_word(input logic [fqkr_pkg::OP_W-1:0] op,
                            input logic signed [fqkr_pkg::ID_W-1:0] id,
                            input logic signed [fqkr_pkg::TAG_W-1:0] tag, input bit typed,
                            input queue_reply_type typed_reply);
      queue_reply_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.item_id   <= id;
      req_bus.item_tag  <= tag;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = apply_queue_op(op, id, tag);
      awaited_replies.push_back(typed ? typed_reply : predicted);
   endtask

   task automatic send_random_word(input bit fill_bias);
      logic [fqkr_pkg::OP_W-1:0]         op;
      logic signed [fqkr_pkg::ID_W-1:0]  id;
      logic signed [fqkr_pkg::TAG_W-1:0] tag;
      int                                r;
      int                                enq_pct;
      int                                pos;
      r       = $urandom_range(99);
      enq_pct = fill_bias ? 55 : 25;
      id      = pick_value();
      tag     = pick_value();
      if (r < enq_pct) begin
         op = fqkr_pkg::OP_ENQUEUE;
      end else if (r < enq_pct + 25) begin
         op = fqkr_pkg::OP_DEQUEUE;
      end else if (r < 93) begin
         op = fqkr_pkg::OP_REMOVE;
         if (model_entries.size() > 0 && $urandom_range(3) != 0) begin
            pos = $urandom_range(model_entries.size() - 1);
            id  = model_entries[pos].id;
            tag = model_entries[pos].tag;
            // near miss on one bit of the key
            if ($urandom_range(4) == 0) begin
               if ($urandom_range(1)) tag = tag ^ (32'sd1 << $urandom_range(31));
               else                   id  = id ^ (32'sd1 << $urandom_range(31));
            end
         end
      end else begin
         op = OP_UNUSED;
      end
      send_word(op, id, tag, 1'b0, '0);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("reply %0d: %s got %h expected %h", reply_count, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_replies
      queue_reply_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_replies.size() == 0) begin
            report_mismatch("unexpected word, out_id", rsp_bus.out_id, 32'd0);
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_bus.ok !== want.ok)
               report_mismatch("ok", 32'(rsp_bus.ok), 32'(want.ok));
            if (rsp_bus.out_id !== want.out_id)
               report_mismatch("out_id", rsp_bus.out_id, want.out_id);
            if (rsp_bus.out_tag !== want.out_tag)
               report_mismatch("out_tag", rsp_bus.out_tag, want.out_tag);
            if (rsp_bus.occupancy !== want.occupancy)
               report_mismatch("occupancy", 32'(rsp_bus.occupancy), 32'(want.occupancy));
            if (rsp_bus.is_empty !== want.is_empty)
               report_mismatch("is_empty", 32'(rsp_bus.is_empty), 32'(want.is_empty));
         end
         reply_count++;
      end
   end

   // receiver: random stalls, plus one long hold-off when the last phase starts
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (phase_idx == 2 && !hold_done) begin
            hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int send_pct [3];
      int recv_pct [3];
      send_pct = '{17, 61, 0};
      recv_pct = '{61, 17, 0};
      clock             = 1'b0;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.operation = fqkr_pkg::OP_ENQUEUE;
      req_bus.item_id   = '0;
      req_bus.item_tag  = '0;
      send_idle_pct     = send_pct[0];
      recv_idle_pct     = recv_pct[0];
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         for (int k = 0; k < script[i].reps; k++) begin
            send_word(script[i].op, script[i].id + k, script[i].tag - k,
                      script[i].typed, script[i].reply);
         end
      end

      for (int p = 0; p < 3; p++) begin
         phase_idx     = p;
         send_idle_pct = send_pct[p];
         recv_idle_pct = recv_pct[p];
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            send_random_word(((n / 60) % 2) == 0);
         end
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/fqkr_pkg.sv
rtl/core/fqkr_ifs.sv
rtl/core/fqkr_cell.sv
rtl/core/fifo_queue_with_keyed_removal.sv
rtl/core/fqkr_checker.sv
tb/sv/fifo_queue_with_keyed_removal_tb.sv
